// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console character writer
// Item formats, operation and register codes, character codes, sizes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CELL_W      = 16;

	// Operation codes of the input item.
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	localparam logic [3:0] FG_RESET = 4'd2;
	localparam logic [3:0] BG_RESET = 4'd0;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] cell_word;
		logic [10:0] cursor_offset;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer: text-mode console with cursor
// ROWS x COLUMNS store of attribute/character cells with put, read and clear.
// ----------------------------------------------------------------------------
// The block works on one item at a time. A put of an ordinary character, a
// newline or wrap that stays above the bottom row, and an unused op go
// straight to the result state; a read passes through a read state first
// because the cell store has registered read data. A clear sweeps the whole
// store through its single write port. A newline or wrap on the bottom row
// scrolls: every row below the top is read and written back one row up, and
// the bottom row is refilled with blanks, after the wrapping character if
// any. After reset the block runs a clearing pass that zeroes the store, and
// accepts no item until it is done; configuration writes are taken at any
// time. Results sit in an output register, so the next item can be accepted
// while the last result is still waiting to be taken.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcw_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output tcw_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [3:0] fg_q;
	logic [3:0] bg_q;

	logic                       res_valid;
	logic                       res_ready;
	tcw_pkg::out_item_t         res_item;
	logic                       out_valid_q;
	tcw_pkg::out_item_t         out_item_q;

	logic                       mem_wr_en;
	logic [AW-1:0]              mem_wr_addr;
	logic [tcw_pkg::CELL_W-1:0] mem_wr_data;
	logic                       mem_rd_en;
	logic [AW-1:0]              mem_rd_addr;
	logic [tcw_pkg::CELL_W-1:0] mem_rd_data;

	// Color registers; the attribute byte is background in the upper nibble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcw_pkg::CFG_FG: fg_q <= cfg_data;
				tcw_pkg::CFG_BG: bg_q <= cfg_data;
			endcase
		end
	end

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CELLS   (CELLS),
		.AW      (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.attr        ({bg_q, fg_q}),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Output register: takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: rtl/core/tcw_cell_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram: screen cell store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [tcw_pkg::CELL_W-1:0] rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: cursor and sequencer of the text console
// Runs put, read, clear and scroll against the cell store.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF,
	parameter int CELLS   = COLUMNS * ROWS,
	parameter int AW      = $clog2(CELLS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tcw_pkg::in_item_t          in_item,
	input  logic [7:0]                 attr,
	output logic                       res_valid,
	input  logic                       res_ready,
	output tcw_pkg::out_item_t         res_item,
	output logic                       mem_wr_en,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [tcw_pkg::CELL_W-1:0] mem_wr_data,
	output logic                       mem_rd_en,
	output logic [AW-1:0]              mem_rd_addr,
	input  logic [tcw_pkg::CELL_W-1:0] mem_rd_data
);

	localparam int RW  = $clog2(ROWS);
	localparam int CLW = $clog2(COLUMNS + 1);

	tcw_pkg::state_t state_q, state_d;

	logic [RW-1:0]  row_q;
	logic [CLW-1:0] col_q;
	logic [AW-1:0]  base_q;
	logic [AW:0]    cnt_q;
	logic           put_pend_q;
	logic [7:0]     char_q;
	logic           rd_ok_q;
	logic [15:0]    word_q;

	logic           accept;
	logic           bottom;
	logic           row_full;
	logic           is_nl;
	logic           idx_ok;
	logic [AW+1:0]  scr_rd;
	logic [AW:0]    scr_wr;
	logic [AW:0]    offset;
	logic [15:0]    blank;

	assign accept   = (state_q == tcw_pkg::ST_IDLE) && in_valid;
	assign bottom   = (row_q == RW'(ROWS - 1));
	assign row_full = (col_q == CLW'(COLUMNS));
	assign is_nl    = (in_item.char_code == tcw_pkg::NEWLINE_CODE);
	assign idx_ok   = ({21'd0, in_item.cell_index} < 32'(CELLS));
	assign scr_rd   = (AW+2)'(cnt_q) + (AW+2)'(COLUMNS);
	assign scr_wr   = cnt_q - (AW+1)'(1);
	assign offset   = (AW+1)'(base_q) + (AW+1)'(col_q);
	assign blank    = {attr, tcw_pkg::SPACE_CODE};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (cnt_q == (AW+1)'(CELLS - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_item.op)
						tcw_pkg::OP_PUT: begin
							if (bottom && (is_nl || row_full)) begin
								state_d = tcw_pkg::ST_SCROLL;
							end else begin
								state_d = tcw_pkg::ST_DONE;
							end
						end
						tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_READ;
						tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_FILL;
						default:           state_d = tcw_pkg::ST_DONE;
					endcase
				end
			end
			tcw_pkg::ST_READ: state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q == (AW+1)'(CELLS)) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_FILL: begin
				if (cnt_q == (AW+1)'(CELLS - 1)) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// Memory port and handshake outputs.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = base_q;
		mem_wr_data = {attr, in_item.char_code};
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(in_item.cell_index);
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = cnt_q[AW-1:0];
				mem_wr_data = '0;
			end
			tcw_pkg::ST_FILL: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = cnt_q[AW-1:0];
				mem_wr_data = blank;
			end
			tcw_pkg::ST_IDLE: begin
				if (in_valid && in_item.op == tcw_pkg::OP_PUT && !is_nl) begin
					if (!row_full) begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = AW'(offset);
					end else if (!bottom) begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = AW'((AW+1)'(base_q) + (AW+1)'(COLUMNS));
					end
				end
				if (in_valid && in_item.op == tcw_pkg::OP_READ) begin
					mem_rd_en = idx_ok;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				// Reads run one cell ahead of the writes, one row further down.
				mem_rd_en   = (scr_rd < (AW+2)'(CELLS));
				mem_rd_addr = scr_rd[AW-1:0];
				mem_wr_en   = (cnt_q != '0);
				mem_wr_addr = scr_wr[AW-1:0];
				if (scr_wr < (AW+1)'(CELLS - COLUMNS)) begin
					mem_wr_data = mem_rd_data;
				end else if (put_pend_q && scr_wr == (AW+1)'(CELLS - COLUMNS)) begin
					mem_wr_data = {attr, char_q};
				end else begin
					mem_wr_data = blank;
				end
			end
			default: ;
		endcase
	end

	assign in_ready               = (state_q == tcw_pkg::ST_IDLE);
	assign res_valid              = (state_q == tcw_pkg::ST_DONE);
	assign res_item.cell_word     = word_q;
	assign res_item.cursor_offset = 11'(offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::ST_INIT;
			row_q      <= '0;
			col_q      <= '0;
			base_q     <= '0;
			cnt_q      <= '0;
			put_pend_q <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tcw_pkg::ST_INIT, tcw_pkg::ST_FILL, tcw_pkg::ST_SCROLL: begin
					cnt_q <= cnt_q + (AW+1)'(1);
				end
				default: cnt_q <= '0;
			endcase
			if (accept) begin
				put_pend_q <= 1'b0;
				rd_ok_q    <= idx_ok;
				case (in_item.op)
					tcw_pkg::OP_PUT: begin
						if (is_nl || row_full) begin
							if (!bottom) begin
								row_q  <= row_q + RW'(1);
								base_q <= base_q + AW'(COLUMNS);
							end
							col_q      <= is_nl ? '0 : CLW'(1);
							put_pend_q <= !is_nl && bottom;
						end else begin
							col_q <= col_q + CLW'(1);
						end
					end
					tcw_pkg::OP_CLEAR: begin
						row_q  <= '0;
						col_q  <= '0;
						base_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= in_item.char_code;
			word_q <= '0;
		end else if (state_q == tcw_pkg::ST_READ) begin
			word_q <= rd_ok_q ? mem_rd_data : '0;
		end
	end

	a_scroll_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
		else $error("read and write hit the same cell");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) <= COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor out of range");

	a_base_tracks_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(base_q) == 32'(row_q) * COLUMNS)
		else $error("row base out of step with row");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(word_q) && $stable(offset)))
		else $error("pending result changed");

endmodule

// File: tb/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: result predictor and comparator for the console writer
// Watches the item, result and register channels and keeps a shadow of the
// screen, cursor and colors. Each result is checked against the oldest
// predicted item result.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  tcw_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  tcw_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	output int                 mismatches,
	output int                 waiting
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;

	logic [15:0] shadow_screen [CELLS];
	int unsigned cur_row;
	int unsigned cur_col;
	logic [3:0]  fg_nib;
	logic [3:0]  bg_nib;
	out_item_t   pending_results [$];
	int          fail_total;

	assign mismatches = fail_total;
	assign waiting    = pending_results.size();

	function automatic logic [15:0] styled_cell(logic [7:0] ch);
		return {bg_nib, fg_nib, ch};
	endfunction

	function automatic void line_feed();
		if (cur_row >= ROWS - 1) begin
			for (int i = COLUMNS; i < CELLS; i++)
				shadow_screen[i - COLUMNS] = shadow_screen[i];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				shadow_screen[i] = styled_cell(SPACE_CODE);
			cur_row = ROWS - 1;
		end else begin
			cur_row++;
		end
		cur_col = 0;
	endfunction

	function automatic out_item_t console_step(in_item_t it);
		out_item_t   res;
		int unsigned pos;
		res = '0;
		case (it.op)
			OP_PUT: begin
				if (it.char_code == NEWLINE_CODE) begin
					line_feed();
				end else begin
					if (cur_col >= COLUMNS)
						line_feed();
					shadow_screen[cur_row * COLUMNS + cur_col] = styled_cell(it.char_code);
					cur_col++;
				end
			end
			OP_READ: begin
				if (it.cell_index < CELLS)
					res.cell_word = shadow_screen[it.cell_index];
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					shadow_screen[i] = styled_cell(SPACE_CODE);
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
			end
		endcase
		pos = cur_row * COLUMNS + cur_col;
		res.cursor_offset = pos[10:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				shadow_screen[i] = '0;
			cur_row = 0;
			cur_col = 0;
			fg_nib = FG_RESET;
			bg_nib = BG_RESET;
			pending_results.delete();
			fail_total = 0;
		end else begin
			// Results first, so an item accepted at this edge never meets
			// a result that belongs to an older item.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: unexpected result cell_word %h cursor %0d",
							$realtime, out_item.cell_word, out_item.cursor_offset);
				end else begin
					want = pending_results.pop_front();
					if (out_item.cell_word !== want.cell_word ||
						out_item.cursor_offset !== want.cursor_offset) begin
						fail_total++;
						if (fail_total <= 10)
							$display("%0t: mismatch: expected cell_word %h cursor %0d, got cell_word %h cursor %0d",
								$realtime, want.cell_word, want.cursor_offset,
								out_item.cell_word, out_item.cursor_offset);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_FG)
					fg_nib = cfg_data;
				else
					bg_nib = cfg_data;
			end
			if (in_valid && in_ready)
				pending_results.push_back(console_step(in_item));
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the text console character writer
// Drives a directed opening and then phases of random console traffic under
// changing colors and handshake pacing; a checker beside the block predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
	import tcw_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS    = ROWS_DEF;
	localparam int CELLS   = ROWS * COLUMNS;

	// The op code that the block leaves unused; it must change nothing.
	localparam logic [1:0] OP_NONE = 2'd3;

	// Index range of the 11-bit cell address field, out-of-range part included.
	localparam int INDEX_MAX = 2047;

	// Length of the receiver hold-off used to back the block up.
	localparam int HOLD_CYCLES = 400;

	// Least number of random items per phase, beyond the fixed warm-up of the first phase.
	localparam int PHASE_ITEMS = 15;
	localparam int PHASES      = 6;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_we    = 1'b0;
	logic      cfg_index = CFG_FG;
	logic [3:0] cfg_data = '0;

	int  mismatches;
	int  waiting;
	int  items_sent     = 0;
	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_go        = 1'b0;
	logic hold_off      = 1'b0;

	text_console_char_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcw_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver draws a fresh ready every cycle. During the long hold-off
	// it refuses everything, so the output register fills and the block has
	// to stall its input while the sender keeps offering items.
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The hold-off counts its own cycles, independent of the sender.
	initial begin : long_hold
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// A correct run takes a few milliseconds at most; this is many times the
	// worst case of every item scrolling behind the slowest receiver.
	initial begin : watchdog
		#60_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic in_item_t make_item(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
		in_item_t it;
		it.op         = op;
		it.char_code  = ch;
		it.cell_index = idx;
		return it;
	endfunction

	// Reads aim at the top rows, the bottom row that scrolling refills, the
	// addresses past the end of the screen, and anywhere at all.
	function automatic logic [10:0] read_index();
		case ($urandom_range(3))
			0:       return 11'($urandom_range(2 * COLUMNS - 1));
			1:       return 11'($urandom_range(CELLS - 1, CELLS - COLUMNS));
			2:       return 11'($urandom_range(INDEX_MAX, CELLS));
			default: return 11'($urandom_range(INDEX_MAX));
		endcase
	endfunction

	// Offers one item and returns at the edge where it is taken. Valid stays
	// high afterwards; the next call either replaces the payload at once or
	// drops valid for a gap, so valid is never lowered and raised in one step.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		items_sent++;
	endtask

	task automatic put_newline();
		send_item(make_item(OP_PUT, NEWLINE_CODE, 11'($urandom_range(INDEX_MAX))));
	endtask

	// A run of printable and unprintable characters alike; a newline code
	// that turns up by chance is part of the traffic too.
	task automatic put_text(input int count);
		repeat (count)
			send_item(make_item(OP_PUT, 8'($urandom_range(255)),
				11'($urandom_range(INDEX_MAX))));
	endtask

	// Waits for every result to come back; registers are only touched then.
	// The first edge lets the checker log the item taken at the last edge.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes foreground and then background on consecutive edges.
	task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FG;
		cfg_data  <= fg;
		@(posedge clk);
		cfg_index <= CFG_BG;
		cfg_data  <= bg;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 0;
			end
			PACE_SEND_IDLE: begin
				send_idle_pct  = 86;
				recv_stall_pct <= 0;
			end
			PACE_RECV_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 86;
			end
			default: begin
				send_idle_pct  = 17;
				recv_stall_pct <= 17;
			end
		endcase
	endtask

	// One burst of console traffic. Most of it is text with line ends, so
	// the cursor keeps reaching the bottom row, wrapping and scrolling;
	// reads look back at what was written, and a little noise is mixed in.
	task automatic run_sequence();
		int pick;
		int count;
		pick = $urandom_range(99);
		if (pick < 40) begin
			if ($urandom_range(4) == 0)
				count = $urandom_range(90, 75);
			else
				count = $urandom_range(20);
			put_text(count);
			if ($urandom_range(9) < 7)
				put_newline();
		end else if (pick < 60) begin
			count = $urandom_range(8, 1);
			repeat (count)
				put_newline();
		end else if (pick < 85) begin
			count = $urandom_range(6, 1);
			repeat (count)
				send_item(make_item(OP_READ, 8'($urandom_range(255)), read_index()));
		end else if (pick < 90) begin
			send_item(make_item(OP_CLEAR, 8'($urandom_range(255)),
				11'($urandom_range(INDEX_MAX))));
		end else begin
			count = $urandom_range(3, 1);
			repeat (count) begin
				if ($urandom_range(1) == 0)
					send_item(make_item(OP_NONE, 8'($urandom_range(255)),
						11'($urandom_range(INDEX_MAX))));
				else
					send_item(make_item(2'($urandom_range(3)), 8'($urandom_range(255)),
						11'($urandom_range(INDEX_MAX))));
			end
		end
	endtask

	initial begin : stimulus
		int phase_end;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset colors. The first items wait for
		// the clearing pass by way of the handshake.
		send_item(make_item(OP_READ, 8'h00, 11'd0));
		send_item(make_item(OP_READ, 8'hFF, 11'(CELLS - 1)));
		send_item(make_item(OP_READ, 8'h00, 11'(CELLS)));
		send_item(make_item(OP_READ, 8'hFF, 11'(INDEX_MAX)));
		send_item(make_item(OP_NONE, 8'hFF, 11'(INDEX_MAX)));
		send_item(make_item(OP_NONE, 8'h00, 11'd0));
		send_item(make_item(OP_PUT, 8'h00, 11'(INDEX_MAX)));
		// Codes above 127 must land in the cell as plain unsigned bytes.
		send_item(make_item(OP_PUT, 8'hFF, 11'd0));
		send_item(make_item(OP_PUT, 8'h80, 11'(INDEX_MAX)));
		send_item(make_item(OP_PUT, 8'h41, 11'd0));
		send_item(make_item(OP_READ, 8'h00, 11'd0));
		send_item(make_item(OP_READ, 8'h00, 11'd1));
		send_item(make_item(OP_READ, 8'h00, 11'd2));
		send_item(make_item(OP_READ, 8'h00, 11'd3));
		send_item(make_item(OP_READ, 8'h00, 11'd4));
		// After a newline the next character must go to column zero.
		put_newline();
		send_item(make_item(OP_PUT, 8'h7F, 11'd0));
		send_item(make_item(OP_READ, 8'h00, 11'(COLUMNS)));
		send_item(make_item(OP_READ, 8'h00, 11'(COLUMNS + 1)));
		send_item(make_item(OP_CLEAR, 8'hFF, 11'(INDEX_MAX)));
		send_item(make_item(OP_READ, 8'h00, 11'd0));
		send_item(make_item(OP_READ, 8'h00, 11'(CELLS - 1)));
		send_item(make_item(OP_READ, 8'h00, 11'(CELLS)));
		put_newline();
		send_item(make_item(OP_PUT, SPACE_CODE, 11'd0));

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0:       set_colors(4'hF, 4'hF);
				1:       set_colors(4'h0, 4'h0);
				3:       set_colors(4'hF, 4'h0);
				4:       set_colors(4'h0, 4'hF);
				default: set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
			endcase
			set_pace(pace_t'(phase % 4));
			if (phase == 4)
				hold_go = 1'b1;
			if (phase == 0) begin
				// Wrap in the middle of the screen, walk down to the
				// bottom row and scroll by newline, then wrap there so the
				// wrap itself has to scroll.
				put_text(85);
				repeat (ROWS + 1)
					put_newline();
				put_text(85);
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				run_sequence();
		end

		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
